[rtl/core/ist_pkg.sv]
`default_nettype none

package ist_pkg;

	localparam int unsigned SET_CAPACITY_DEF = 16;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic               was_present;
		logic               rejected_full;
		logic [COUNT_W-1:0] element_count;
	} rsp_t;

	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] value;
	} slot_t;

endpackage

`default_nettype wire

[rtl/core/ist_req_if.sv]
`default_nettype none

interface ist_req_if;
	import ist_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/core/ist_rsp_if.sv]
`default_nettype none

interface ist_rsp_if;
	import ist_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/core/integer_set_table.sv]
// Set of unique signed 32-bit values held in SET_CAPACITY slots of one memory, each
// slot with its own valid mark. Every request word (insert, remove or query) yields
// exactly one response word carrying whether the value was present before the
// operation, whether an insert was dropped because the table was full, and the
// low five bits of the element count afterward. After a request is accepted, the
// single memory read port scans one slot per cycle into one shared comparator,
// a register stage carries the last slot read into the comparator, and a final
// state writes the chosen slot and registers the response word. The next request
// can be accepted in the cycle after that; a new request is not taken until the
// previous one has been through its final state.
// A new request may be accepted while the previous response still waits, but its
// final cycle stalls until that response has been taken. After reset the block clears
// the valid marks of every slot before it accepts its first request.
`default_nettype none

module integer_set_table #(
	parameter int unsigned SET_CAPACITY = ist_pkg::SET_CAPACITY_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	ist_req_if.sink   req,
	ist_rsp_if.source rsp
);
	import ist_pkg::*;

	localparam int unsigned IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
	localparam int unsigned CW = $clog2(SET_CAPACITY + 1);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	slot_t mem [SET_CAPACITY];

	logic [1:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      members_q;
	logic [1:0]         kind_q;
	logic [VALUE_W-1:0] value_q;
	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic               chk_s1;
	logic [IW-1:0]      idx_s1;
	slot_t              rd_s1;
	logic               rsp_vld_q;
	rsp_t               rsp_q;

	logic               mem_we;
	logic [IW-1:0]      mem_wa;
	slot_t              mem_wd;
	logic               finish_go;
	logic               do_insert;
	logic               do_remove;
	logic [CW-1:0]      members_nxt;
	logic [CW+4:0]      members_ext;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	assign finish_go = (state_q == ST_FINISH) && (!rsp_vld_q || rsp.ready);
	assign do_insert = (kind_q == KIND_INSERT) && !hit_q && free_q;
	assign do_remove = (kind_q == KIND_REMOVE) && hit_q;

	always_comb begin
		members_nxt = members_q;
		if (do_insert) begin
			members_nxt = members_q + CW'(1);
		end else if (do_remove) begin
			members_nxt = members_q - CW'(1);
		end
		members_ext = (CW + 5)'(members_nxt);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q[IW-1:0];
		mem_wd = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (finish_go && do_insert) begin
			mem_we       = 1'b1;
			mem_wa       = free_idx_q;
			mem_wd.valid = 1'b1;
			mem_wd.value = value_q;
		end else if (finish_go && do_remove) begin
			mem_we = 1'b1;
			mem_wa = hit_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_s1 <= mem[cnt_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
		if (req.valid && req.ready) begin
			kind_q  <= req.data.kind;
			value_q <= req.data.value;
		end
		if (finish_go) begin
			rsp_q.was_present   <= hit_q;
			rsp_q.rejected_full <= (kind_q == KIND_INSERT) && !hit_q && !free_q;
			rsp_q.element_count <= members_ext[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			members_q  <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			chk_s1     <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			chk_s1 <= (state_q == ST_SCAN) && (cnt_q != CW'(SET_CAPACITY));
			if (finish_go) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (chk_s1) begin
				if (rd_s1.valid && (rd_s1.value == value_q)) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_s1;
				end
				if (!rd_s1.valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == CW'(SET_CAPACITY - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CW'(SET_CAPACITY)) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						members_q <= members_nxt;
						cnt_q     <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[sim/integer_set_table_checker.sv]
module integer_set_table_checker #(
	parameter int unsigned CAPACITY = ist_pkg::SET_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ist_req_if   req_mon,
	ist_rsp_if   rsp_mon,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ist_pkg::*;

	logic [VALUE_W-1:0] slot_val [CAPACITY];
	logic               slot_vld [CAPACITY];
	int unsigned        members;
	rsp_t               answers_owed [$];
	int                 mismatches;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		mismatches++;
		if (mismatches <= 50) begin
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
		end
	endtask

	task automatic apply_set_op(input req_t op, output rsp_t answer);
		int hit;
		int free_slot;
		hit = -1;
		free_slot = -1;
		answer = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit < 0 && slot_vld[i] && slot_val[i] == op.value) begin
				hit = i;
			end
			if (free_slot < 0 && !slot_vld[i]) begin
				free_slot = i;
			end
		end
		if (op.kind == KIND_INSERT && hit < 0) begin
			if (free_slot < 0) begin
				answer.rejected_full = 1'b1;
			end else begin
				slot_val[free_slot] = op.value;
				slot_vld[free_slot] = 1'b1;
				members++;
			end
		end else if (op.kind == KIND_REMOVE && hit >= 0) begin
			slot_vld[hit] = 1'b0;
			if (members > 0) begin
				members--;
			end
		end
		answer.was_present = (hit >= 0);
		answer.element_count = members[COUNT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t owed;
		rsp_t got;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				slot_vld[i] = 1'b0;
				slot_val[i] = '0;
			end
			members = 0;
			answers_owed.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				got = rsp_mon.data;
				if (answers_owed.size() == 0) begin
					report_mismatch("response word with nothing outstanding", 0, 1);
				end else begin
					owed = answers_owed.pop_front();
					if (got.was_present !== owed.was_present) begin
						report_mismatch("was_present", owed.was_present, got.was_present);
					end
					if (got.rejected_full !== owed.rejected_full) begin
						report_mismatch("rejected_full", owed.rejected_full,
							got.rejected_full);
					end
					if (got.element_count !== owed.element_count) begin
						report_mismatch("element_count", owed.element_count,
							got.element_count);
					end
				end
			end
			if (req_mon.valid && req_mon.ready) begin
				apply_set_op(req_mon.data, owed);
				answers_owed.push_back(owed);
			end
			pending <= answers_owed.size();
		end
	end

endmodule

[sim/integer_set_table_tb.sv]
module integer_set_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ist_pkg::*;

	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 12;
	localparam int PHASE_WORDS = 150;
	localparam int POOL_MAX = 40;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	bit   no_gaps = 0;

	logic [VALUE_W-1:0] pool_vals [POOL_MAX];

	ist_req_if req_ch();
	ist_rsp_if rsp_ch();

	integer_set_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	integer_set_table_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_mon(req_ch),
		.rsp_mon(rsp_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 70) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(input logic [1:0] k, input logic [VALUE_W-1:0] v);
		req_t w;
		int gap;
		w.kind = k;
		w.value = v;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value(input int pool_size);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			return $urandom();
		end else if (r < 20) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return pool_vals[$urandom_range(0, pool_size - 1)];
	endfunction

	function automatic logic [1:0] pick_kind(input int ins_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_pct) begin
			return KIND_INSERT;
		end else if (r < ins_pct + 25) begin
			return KIND_REMOVE;
		end else if (r < 95) begin
			return KIND_QUERY;
		end
		return KIND_SPARE;
	endfunction

	// Receiver: runs of ready high and low, mostly short stalls with a few long ones.
	initial begin
		int   run_len;
		logic level;
		run_len = 0;
		level = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (run_len == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						level = 1'b1;
						run_len = $urandom_range(1, 12);
					end
					4: begin
						level = 1'b1;
						run_len = $urandom_range(100, 300);
					end
					5, 6, 7, 8: begin
						level = 1'b0;
						run_len = $urandom_range(1, 3);
					end
					default: begin
						level = 1'b0;
						run_len = $urandom_range(10, 40);
					end
				endcase
			end
			rsp_ch.ready <= level;
			run_len--;
			@(posedge clk);
		end
	end

	initial begin
		int pool_size;
		int ins_pct;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(KIND_QUERY, 32'h5A5A_A5A5);
		send_word(KIND_INSERT, 32'h8000_0000);
		send_word(KIND_INSERT, 32'h7FFF_FFFF);
		send_word(KIND_INSERT, 32'h0000_0000);
		send_word(KIND_INSERT, 32'hFFFF_FFFF);
		send_word(KIND_INSERT, 32'h0000_0000);
		send_word(KIND_QUERY, 32'h7FFF_FFFF);
		send_word(KIND_SPARE, 32'hFFFF_FFFF);
		send_word(KIND_REMOVE, 32'h0000_0000);
		send_word(KIND_REMOVE, 32'h0000_0000);
		for (int i = 1; i <= 13; i++) begin
			send_word(KIND_INSERT, i);
		end
		send_word(KIND_INSERT, 32'd100);
		send_word(KIND_INSERT, 32'hFFFF_FFFF);
		send_word(KIND_REMOVE, 32'h7FFF_FFFF);
		send_word(KIND_INSERT, 32'h0000_0000);

		// Each phase draws mostly from its own pool; the upper half of the pool array
		// is one bit off the lower half, so the table fills, drains and sees near misses.
		for (int p = 0; p < PHASES; p++) begin
			pool_size = $urandom_range(4, POOL_MAX);
			ins_pct = $urandom_range(30, 60);
			no_gaps = ($urandom_range(0, 2) == 0);
			for (int j = 0; j < POOL_MAX; j++) begin
				if (j < POOL_MAX / 2) begin
					pool_vals[j] = $urandom();
				end else begin
					pool_vals[j] = pool_vals[j - POOL_MAX / 2] ^ (32'd1 << $urandom_range(0, 31));
				end
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				send_word(pick_kind(ins_pct), pick_value(pool_size));
			end
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
